>>> sv/bblc_pkg.sv
`default_nettype none

package bblc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int SIZE_BITS  = 24;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int EVICT_W    = 5;
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	localparam logic [SIZE_BITS-1:0]  BUDGET_RESET     = SIZE_BITS'(65536);
	localparam logic [APB_ADDR_W-1:0] ADDR_BYTE_BUDGET = APB_ADDR_W'(0);

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [KEY_BITS-1:0]  key_t;
	typedef logic [SIZE_BITS-1:0] size_t_t;
	typedef logic [EVICT_W-1:0]   evict_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_LOOKUP = 8'b0000_0010,
		ST_HIT    = 8'b0000_0100,
		ST_CHECK  = 8'b0000_1000,
		ST_SCAN   = 8'b0001_0000,
		ST_EVICT  = 8'b0010_0000,
		ST_INSERT = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

>>> sv/bblc_req_if.sv
`default_nettype none

interface bblc_req_if import bblc_pkg::*; ();
	logic    valid;
	logic    ready;
	key_t    key_id;
	size_t_t item_size;

	modport source (output valid, output key_id, output item_size, input ready);
	modport sink (input valid, input key_id, input item_size, output ready);
endinterface

`default_nettype wire

>>> sv/bblc_rsp_if.sv
`default_nettype none

interface bblc_rsp_if import bblc_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    hit;
	logic    stored;
	evict_t  evicted_count;
	size_t_t bytes_in_use;

	modport source (output valid, output hit, output stored, output evicted_count,
		output bytes_in_use, input ready);
	modport sink (input valid, input hit, input stored, input evicted_count,
		input bytes_in_use, output ready);
endinterface

`default_nettype wire

>>> sv/byte_budget_lru_cache.sv
// channel   dir   beat contents
// -------   ---   ------------------------------------------------
// req       in    key_id, item_size
// rsp       out   hit, stored, evicted_count, bytes_in_use
// apb       in    byte_budget at address 0, read back on prdata
//
// one shared compare unit walks the 16 slots, one slot a cycle
// hit: lookup stops at the matching slot, then ST_HIT and ST_DONE, which loads the rsp beat
// miss: lookup of all 16 slots, ST_CHECK, ST_INSERT if stored, ST_DONE; each eviction adds ST_SCAN, ST_EVICT
// each eviction is a full 16-slot scan for the least recent entry
// reset clears all valid bits at once, no clearing pass
// req is taken only when idle, in the cycle after the rsp beat is loaded; a held rsp beat stalls it
`default_nettype none

module byte_budget_lru_cache import bblc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	bblc_req_if.sink                   req,
	bblc_rsp_if.source                 rsp,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	state_t              state_q;
	idx_t                idx_q;
	key_t                key_q;
	size_t_t             size_q;
	logic [ENTRIES-1:0]  valid_q;
	cnt_t                count_q;
	size_t_t             used_q;
	size_t_t             budget_q;
	idx_t                found_idx_q;
	idx_t                found_rank_q;
	idx_t                free_idx_q;
	logic                free_ok_q;
	idx_t                best_idx_q;
	idx_t                best_rank_q;
	logic                best_ok_q;
	logic                hit_q;
	logic                stored_q;
	evict_t              evicted_q;
	logic                rsp_valid_q;
	logic                rsp_hit_q;
	logic                rsp_stored_q;
	evict_t              rsp_evicted_q;
	size_t_t             rsp_bytes_q;

	key_t                slot_key_q  [ENTRIES];
	size_t_t             slot_bytes_q[ENTRIES];
	idx_t                slot_rank_q [ENTRIES];

	logic                last_slot;
	logic                key_match;
	idx_t                rank_here;
	logic                over_budget;
	logic                fits;
	logic                table_full;
	size_t_t             victim_bytes;
	size_t_t             used_after_evict;
	logic                cfg_write;

	assign last_slot    = (idx_q == IDX_W'(ENTRIES - 1));
	assign key_match    = valid_q[idx_q] && (slot_key_q[idx_q] == key_q);
	assign rank_here    = slot_rank_q[idx_q];
	assign over_budget  = ({1'b0, used_q} + {1'b0, size_q}) > {1'b0, budget_q};
	assign fits         = (size_q <= budget_q);
	assign table_full   = (count_q == CNT_W'(ENTRIES));
	assign victim_bytes = slot_bytes_q[best_idx_q];
	assign used_after_evict = (used_q >= victim_bytes) ? (used_q - victim_bytes) : '0;
	assign cfg_write    = psel && penable && pwrite && (paddr == ADDR_BYTE_BUDGET);

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = rsp_hit_q;
	assign rsp.stored        = rsp_stored_q;
	assign rsp.evicted_count = rsp_evicted_q;
	assign rsp.bytes_in_use  = rsp_bytes_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_BYTE_BUDGET) ? APB_DATA_W'(budget_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			key_q         <= '0;
			size_q        <= '0;
			valid_q       <= '0;
			count_q       <= '0;
			used_q        <= '0;
			budget_q      <= BUDGET_RESET;
			found_idx_q   <= '0;
			found_rank_q  <= '0;
			free_idx_q    <= '0;
			free_ok_q     <= 1'b0;
			best_idx_q    <= '0;
			best_rank_q   <= '0;
			best_ok_q     <= 1'b0;
			hit_q         <= 1'b0;
			stored_q      <= 1'b0;
			evicted_q     <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_hit_q     <= 1'b0;
			rsp_stored_q  <= 1'b0;
			rsp_evicted_q <= '0;
			rsp_bytes_q   <= '0;
		end else begin
			if (cfg_write) begin
				budget_q <= pwdata[SIZE_BITS-1:0];
			end
			if (rsp_valid_q && rsp.ready && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						key_q     <= req.key_id;
						size_q    <= req.item_size;
						idx_q     <= '0;
						free_ok_q <= 1'b0;
						hit_q     <= 1'b0;
						stored_q  <= 1'b0;
						evicted_q <= '0;
						state_q   <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (!valid_q[idx_q] && !free_ok_q) begin
						free_ok_q  <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (key_match) begin
						found_idx_q  <= idx_q;
						found_rank_q <= rank_here;
						state_q      <= ST_HIT;
					end else if (last_slot) begin
						state_q <= ST_CHECK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_HIT: begin
					hit_q   <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_CHECK: begin
					if ((over_budget && (count_q != '0)) || (fits && table_full)) begin
						idx_q     <= '0;
						best_ok_q <= 1'b0;
						state_q   <= ST_SCAN;
					end else if (fits) begin
						state_q <= ST_INSERT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (valid_q[idx_q] && (!best_ok_q || (rank_here > best_rank_q))) begin
						best_ok_q   <= 1'b1;
						best_idx_q  <= idx_q;
						best_rank_q <= rank_here;
					end
					if (last_slot) begin
						state_q <= ST_EVICT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EVICT: begin
					valid_q[best_idx_q] <= 1'b0;
					used_q    <= used_after_evict;
					count_q   <= count_q - 1'b1;
					evicted_q <= evicted_q + 1'b1;
					if (!free_ok_q || (best_idx_q < free_idx_q)) begin
						free_ok_q  <= 1'b1;
						free_idx_q <= best_idx_q;
					end
					state_q <= ST_CHECK;
				end
				ST_INSERT: begin
					valid_q[free_idx_q] <= 1'b1;
					used_q   <= used_q + size_q;
					count_q  <= count_q + 1'b1;
					stored_q <= 1'b1;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q   <= 1'b1;
						rsp_hit_q     <= hit_q;
						rsp_stored_q  <= stored_q;
						rsp_evicted_q <= evicted_q;
						rsp_bytes_q   <= used_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// slot payload, read only where the valid bit is set
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (state_q == ST_HIT) begin
				if (IDX_W'(i) == found_idx_q) begin
					slot_rank_q[i] <= '0;
				end else if (valid_q[i] && (slot_rank_q[i] < found_rank_q)) begin
					slot_rank_q[i] <= slot_rank_q[i] + 1'b1;
				end
			end else if (state_q == ST_INSERT) begin
				if (IDX_W'(i) == free_idx_q) begin
					slot_key_q[i]   <= key_q;
					slot_bytes_q[i] <= size_q;
					slot_rank_q[i]  <= '0;
				end else if (valid_q[i]) begin
					slot_rank_q[i] <= slot_rank_q[i] + 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("slot count differs from valid bits");

	a_empty_holds_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (used_q == '0))
		else $error("bytes in use with an empty table");

	a_hit_is_pure: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.hit) |-> (!rsp.stored && (rsp.evicted_count == '0)))
		else $error("hit beat reports a store or eviction");

	a_insert_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT) |-> (free_ok_q && !valid_q[free_idx_q]))
		else $error("insert into an occupied slot");
`endif

endmodule

`default_nettype wire
